@@ src/gsc_pkg.sv @@
package gsc_pkg;

	localparam int SLOT_W = 7;
	localparam int SLOTS  = 1 << SLOT_W;
	localparam int CNT_W  = SLOT_W + 1;
	localparam int GEN_W  = 32;

	localparam logic [1:0] FN_ALLOC    = 2'd0;
	localparam logic [1:0] FN_INVAL    = 2'd1;
	localparam logic [1:0] FN_VALIDATE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFREE   = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [GEN_W-1:0]  gen_t;

	// free stack control, driven at accept time
	typedef struct packed {
		logic  pop;
		logic  push;
		slot_t push_slot;
	} stk_req_t;

	typedef struct packed {
		logic  empty;
		logic  full;
		slot_t pop_slot;
	} stk_rsp_t;

	// generation table control
	typedef struct packed {
		slot_t rd_addr;
		logic  wr;
	} gen_req_t;

	typedef struct packed {
		slot_t addr;
		gen_t  cur;
		gen_t  inc;
	} gen_rsp_t;

endpackage

@@ src/gsc_in_if.sv @@
interface gsc_in_if;
	import gsc_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic        holds_slot;
	slot_t       slot;
	gen_t        expected_generation;

	modport source (output valid, func, holds_slot, slot, expected_generation, input ready);
	modport sink   (input valid, func, holds_slot, slot, expected_generation, output ready);
endinterface

@@ src/gsc_out_if.sv @@
interface gsc_out_if;
	import gsc_pkg::*;

	logic        valid;
	logic        ready;
	slot_t       slot_out;
	gen_t        generation;
	logic        handle_valid;
	logic [1:0]  status;

	modport source (output valid, slot_out, generation, handle_valid, status, input ready);
	modport sink   (input valid, slot_out, generation, handle_valid, status, output ready);
endinterface

@@ src/generational_slot_checker.sv @@
// Generational slot checker: a pool of 128 slots, each with a 32-bit
// generation, and a LIFO of free slot numbers (full after reset, slot 127
// handed out first). Allocate pops a slot, invalidate bumps the slot's
// generation and pushes it back, validate compares the stored generation
// with the one the item brings. Every item gives exactly one result item.
// Rate: one item per cycle while the result side keeps up. The free stack
// is read at accept, the generation table in stage 1 at the popped or named
// slot, and the result is formed and written back in stage 2, then held in
// the output register. The whole pipeline holds while a result waits in the
// output register and is not taken.
module generational_slot_checker (
	input  logic      clk,
	input  logic      arst_n,
	gsc_in_if.sink    req,
	gsc_out_if.source rsp
);
	import gsc_pkg::*;

	logic       en;
	logic       acc;
	stk_req_t   stk_req;
	stk_rsp_t   stk_rsp;
	gen_req_t   gen_req;
	gen_rsp_t   gen_rsp;

	// stage 1: stack read in flight
	logic       valid_s1;
	logic [1:0] func_s1;
	logic       held_s1;
	slot_t      slot_s1;
	gen_t       exp_s1;
	logic       nofree_s1;
	logic       ovf_s1;

	// stage 2: generation read in flight
	logic       valid_s2;
	logic [1:0] func_s2;
	logic       held_s2;
	slot_t      slot_s2;
	gen_t       exp_s2;
	logic       nofree_s2;
	logic       ovf_s2;

	// output register
	logic       out_valid_q;
	slot_t      slot_q;
	gen_t       gen_q;
	logic       hv_q;
	logic [1:0] status_q;

	slot_t      res_slot;
	gen_t       res_gen;
	logic       res_hv;
	logic [1:0] res_status;

	// everything advances together whenever the output register can move
	assign en        = !out_valid_q || rsp.ready;
	assign req.ready = en;
	assign acc       = req.valid && en;

	assign stk_req.pop       = acc && (req.func == FN_ALLOC) && !req.holds_slot;
	assign stk_req.push      = acc && (req.func == FN_INVAL) && req.holds_slot;
	assign stk_req.push_slot = req.slot;

	gsc_free_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.req    (stk_req),
		.rsp    (stk_rsp)
	);

	// unheld alloc looks up the popped slot, everything else the named one
	assign gen_req.rd_addr = (func_s1 == FN_ALLOC && !held_s1) ? stk_rsp.pop_slot : slot_s1;
	assign gen_req.wr      = valid_s2 && (func_s2 == FN_INVAL) && held_s2;

	gsc_gen_table u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.req    (gen_req),
		.rsp    (gen_rsp)
	);

	always_comb begin
		res_slot   = slot_s2;
		res_gen    = '0;
		res_hv     = 1'b0;
		res_status = ST_OK;
		unique case (func_s2)
			FN_ALLOC: begin
				if (held_s2) begin
					res_gen = gen_rsp.cur;
					res_hv  = 1'b1;
				end else if (nofree_s2) begin
					res_slot   = '0;
					res_status = ST_NOFREE;
				end else begin
					res_slot = gen_rsp.addr;
					res_gen  = gen_rsp.cur;
					res_hv   = 1'b1;
				end
			end
			FN_INVAL: begin
				if (held_s2) begin
					res_gen    = gen_rsp.inc;
					res_status = ovf_s2 ? ST_OVERFLOW : ST_OK;
				end else begin
					res_slot = '0;
				end
			end
			FN_VALIDATE: begin
				if (held_s2) begin
					res_gen    = gen_rsp.cur;
					res_hv     = 1'b1;
					res_status = (gen_rsp.cur == exp_s2) ? ST_OK : ST_MISMATCH;
				end else begin
					res_slot   = '0;
					res_status = ST_MISMATCH;
				end
			end
			default: begin
				// unused code: echo the handle, change nothing
				res_gen = held_s2 ? gen_rsp.cur : '0;
				res_hv  = held_s2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= req.valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1   <= req.func;
			held_s1   <= req.holds_slot;
			slot_s1   <= req.slot;
			exp_s1    <= req.expected_generation;
			nofree_s1 <= stk_rsp.empty;
			ovf_s1    <= stk_rsp.full;

			func_s2   <= func_s1;
			held_s2   <= held_s1;
			slot_s2   <= slot_s1;
			exp_s2    <= exp_s1;
			nofree_s2 <= nofree_s1;
			ovf_s2    <= ovf_s1;

			slot_q    <= res_slot;
			gen_q     <= res_gen;
			hv_q      <= res_hv;
			status_q  <= res_status;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.slot_out     = slot_q;
	assign rsp.generation   = gen_q;
	assign rsp.handle_valid = hv_q;
	assign rsp.status       = status_q;
endmodule

@@ src/gsc_ram.sv @@
module gsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ src/gsc_free_stack.sv @@
module gsc_free_stack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  gsc_pkg::stk_req_t req,
	output gsc_pkg::stk_rsp_t rsp
);
	import gsc_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [SLOTS-1:0] vld_q;
	logic             pvld_s1;
	slot_t            pidx_s1;
	slot_t            top_idx;
	slot_t            rdata;
	logic             do_pop;
	logic             do_push;

	assign rsp.empty = (count_q == '0);
	assign rsp.full  = (count_q == CNT_W'(SLOTS));
	assign top_idx   = SLOT_W'(count_q - CNT_W'(1));
	assign do_pop    = en && req.pop && !rsp.empty;
	assign do_push   = en && req.push && !rsp.full;

	gsc_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (count_q[SLOT_W-1:0]),
		.wdata (req.push_slot),
		.re    (en),
		.raddr (top_idx),
		.rdata (rdata)
	);

	// entries never written read as their own index
	assign rsp.pop_slot = pvld_s1 ? rdata : pidx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(SLOTS);
			vld_q   <= '0;
		end else begin
			if (do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end else if (do_push) begin
				count_q                     <= count_q + CNT_W'(1);
				vld_q[count_q[SLOT_W-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pvld_s1 <= vld_q[top_idx];
			pidx_s1 <= top_idx;
		end
	end
endmodule

@@ src/gsc_gen_table.sv @@
module gsc_gen_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  gsc_pkg::gen_req_t req,
	output gsc_pkg::gen_rsp_t rsp
);
	import gsc_pkg::*;

	logic [SLOTS-1:0] vld_q;
	logic             gvld_s2;
	slot_t            addr_s2;
	gen_t             rdata;
	logic             lw_v_q;
	slot_t            lw_addr_q;
	gen_t             lw_data_q;
	logic             do_wr;

	assign do_wr = en && req.wr;

	gsc_ram #(.WIDTH(GEN_W), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (do_wr),
		.waddr (addr_s2),
		.wdata (rsp.inc),
		.re    (en),
		.raddr (req.rd_addr),
		.rdata (rdata)
	);

	// a write at the same edge as this item's read is not in rdata: forward it
	always_comb begin
		rsp.addr = addr_s2;
		if (lw_v_q && (lw_addr_q == addr_s2)) begin
			rsp.cur = lw_data_q;
		end else if (gvld_s2) begin
			rsp.cur = rdata;
		end else begin
			rsp.cur = '0;
		end
		rsp.inc = rsp.cur + GEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			lw_v_q <= 1'b0;
		end else if (en) begin
			lw_v_q <= req.wr;
			if (req.wr) begin
				vld_q[addr_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gvld_s2   <= vld_q[req.rd_addr];
			addr_s2   <= req.rd_addr;
			lw_addr_q <= addr_s2;
			lw_data_q <= rsp.inc;
		end
	end
endmodule

@@ test/generational_slot_checker_tb.sv @@
`timescale 1ns / 1ps

// Testbench for generational_slot_checker.
// A scoreboard model of the slot pool (generation table, free-slot LIFO,
// fill count) is updated on every accepted request item. The expected
// response is queued at that point, and responses are checked in order.
// The traffic imitates a caller holding handles: it allocates, validates
// with the remembered generation, and invalidates. Some stale handles and
// random noise items are mixed in. Both sides idle at random.
module generational_slot_checker_tb;
	import gsc_pkg::*;

	// function code 3 has no meaning in the block and must pass through harmlessly
	localparam logic [1:0] FN_SPARE    = 2'd3;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         STALE_KEEP  = 32;

	typedef struct packed {
		logic [1:0] func;
		logic       held;
		slot_t      slot;
		gen_t       exp_gen;
	} slot_op_t;

	typedef struct packed {
		slot_t      slot;
		gen_t       gen;
		logic       handle_valid;
		logic [1:0] status;
	} slot_res_t;

	// what a caller remembers about one reference
	typedef struct packed {
		slot_t slot;
		gen_t  gen;
	} handle_t;

	logic clk = 1'b0;
	logic arst_n;

	gsc_in_if  req_if();
	gsc_out_if rsp_if();

	generational_slot_checker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// scoreboard copy of the pool
	gen_t  gen_tbl  [SLOTS];
	slot_t free_stk [SLOTS];
	int    free_cnt;

	slot_res_t pending_results [$];
	handle_t   live_handles    [$];
	handle_t   stale_handles   [$];

	int errors       = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int cycles       = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int stall_left   = 0;
	bit src_idle     = 1'b0;
	bit snk_idle     = 1'b0;
	slot_res_t want_res;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// gap length: mostly the shortest, sometimes short, rarely a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 1;
		if (r < 90)
			return $urandom_range(2, 4);
		return $urandom_range(8, 30);
	endfunction

	// Expected response for one request item; updates the pool as the block does.
	function automatic slot_res_t predict_slot_op(input slot_op_t op);
		slot_res_t r;
		slot_t     t;
		r = '0;
		case (op.func)
			FN_ALLOC: begin
				if (op.held) begin
					// handle already names a slot: just report it
					r = '{op.slot, gen_tbl[op.slot], 1'b1, ST_OK};
				end else if (free_cnt == 0) begin
					r.status = ST_NOFREE;
				end else begin
					free_cnt = free_cnt - 1;
					t = free_stk[free_cnt];
					r = '{t, gen_tbl[t], 1'b1, ST_OK};
				end
			end
			FN_INVAL: begin
				r.status = ST_OK;
				if (op.held) begin
					// generation bumps even when the push is refused
					gen_tbl[op.slot] = gen_tbl[op.slot] + 1'b1;
					r.slot = op.slot;
					r.gen  = gen_tbl[op.slot];
					if (free_cnt >= SLOTS) begin
						r.status = ST_OVERFLOW;
					end else begin
						free_stk[free_cnt] = op.slot;
						free_cnt = free_cnt + 1;
					end
				end
			end
			FN_VALIDATE: begin
				if (!op.held)
					r.status = ST_MISMATCH;
				else
					r = '{op.slot, gen_tbl[op.slot], 1'b1,
						(gen_tbl[op.slot] == op.exp_gen) ? ST_OK : ST_MISMATCH};
			end
			default: begin
				r = '{op.slot, op.held ? gen_tbl[op.slot] : gen_t'(0), op.held, ST_OK};
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d (0x%08h) got %0d (0x%08h)", $time, name,
				want, want, got, got);
		end
	endfunction

	// a dropped handle becomes stale; keep only the most recent ones
	function automatic void retire_handle(input handle_t h);
		stale_handles = {stale_handles, h};
		if (stale_handles.size() > STALE_KEEP)
			void'(stale_handles.pop_front());
	endfunction

	// Present one request item, wait for it to be taken, queue its response.
	// valid is left high on return so back-to-back items never toggle it.
	task automatic issue_op(input logic [1:0] func, input logic held, input slot_t slot,
			input gen_t exp_gen, output slot_res_t res);
		slot_op_t op;
		int       gap;
		op  = '{func, held, slot, exp_gen};
		gap = (src_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid               <= 1'b1;
		req_if.func                <= func;
		req_if.holds_slot          <= held;
		req_if.slot                <= slot;
		req_if.expected_generation <= exp_gen;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		res = predict_slot_op(op);
		pending_results = {pending_results, res};
		items_sent++;
	endtask

	// Corner cases from a fresh pool: empty handles, field extremes, the spare
	// code, refused push on a full stack, a push of a slot never handed out.
	task automatic test_directed();
		slot_res_t r;
		issue_op(FN_VALIDATE, 1'b1, 7'd0,   32'd0,         r); // fresh slot, gen 0
		issue_op(FN_VALIDATE, 1'b1, 7'd127, '1,            r); // all-ones compare misses
		issue_op(FN_VALIDATE, 1'b0, 7'd127, 32'd0,         r); // empty handle
		issue_op(FN_INVAL,    1'b0, 7'd127, '1,            r); // empty handle, no effect
		issue_op(FN_SPARE,    1'b0, 7'd127, '1,            r);
		issue_op(FN_ALLOC,    1'b1, 7'd64,  32'd0,         r); // already held
		issue_op(FN_INVAL,    1'b1, 7'd3,   32'd0,         r); // stack full: overflow
		issue_op(FN_SPARE,    1'b1, 7'd3,   32'd0,         r); // shows the bumped gen
		issue_op(FN_ALLOC,    1'b0, 7'd0,   32'd0,         r); // top of stack is 127
		issue_op(FN_ALLOC,    1'b0, 7'd127, '1,            r); // then 126
		issue_op(FN_INVAL,    1'b1, 7'd127, 32'd0,         r); // 127 back on top, gen 1
		issue_op(FN_VALIDATE, 1'b1, 7'd127, 32'd0,         r); // stale reference
		issue_op(FN_VALIDATE, 1'b1, 7'd127, 32'd1,         r);
		issue_op(FN_INVAL,    1'b1, 7'd0,   32'd0,         r); // slot 0 now listed twice
		issue_op(FN_ALLOC,    1'b0, 7'd0,   32'd0,         r);
		issue_op(FN_ALLOC,    1'b0, 7'd0,   32'd0,         r);
		issue_op(FN_ALLOC,    1'b0, 7'd0,   32'd0,         r);
		issue_op(FN_VALIDATE, 1'b1, 7'd0,   32'h5555_5555, r);
		issue_op(FN_VALIDATE, 1'b1, 7'd85,  32'hAAAA_AAAA, r);
		issue_op(FN_SPARE,    1'b1, 7'd42,  32'hFFFF_0000, r);
	endtask

	// Drain the pool until allocation is refused twice, return every slot in random
	// order, then keep invalidating until the full stack refuses a push (at most 200 tries).
	task automatic test_exhaust();
		slot_res_t r;
		handle_t   h;
		int        idx;
		int        refused;
		int        tries;
		refused = 0;
		while (refused < 2) begin
			issue_op(FN_ALLOC, 1'b0, slot_t'($urandom), $urandom, r);
			if (r.status == ST_NOFREE) begin
				refused++;
			end else begin
				h.slot = r.slot;
				h.gen  = r.gen;
				live_handles = {live_handles, h};
			end
		end
		while (live_handles.size() != 0) begin
			idx = $urandom_range(0, live_handles.size() - 1);
			h   = live_handles[idx];
			live_handles.delete(idx);
			issue_op(FN_INVAL, 1'b1, h.slot, $urandom, r);
			retire_handle(h);
		end
		tries = 0;
		do begin
			issue_op(FN_INVAL, 1'b1, slot_t'($urandom), $urandom, r);
			tries++;
		end while (r.status != ST_OVERFLOW && tries < 200);
	endtask

	// Caller-like traffic: mostly well-formed handle use, some stale
	// references, and about one item in ten fully random.
	task automatic test_traffic(input int n);
		slot_res_t  r;
		handle_t    h;
		int         pick;
		int         idx;
		logic [1:0] func;
		logic       held;
		slot_t      slot;
		gen_t       eg;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			idx  = -1;
			func = FN_ALLOC;
			held = 1'b0;
			slot = slot_t'($urandom);
			eg   = $urandom;
			// with no handle in hand the caller can only allocate
			if (live_handles.size() != 0 && pick >= 30 && pick < 90) begin
				idx  = $urandom_range(0, live_handles.size() - 1);
				h    = live_handles[idx];
				held = 1'b1;
				slot = h.slot;
				eg   = h.gen;
				if (pick < 38) begin
					func = FN_ALLOC;
				end else if (pick < 62) begin
					func = FN_VALIDATE;
				end else if (pick < 68 && stale_handles.size() != 0) begin
					h    = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
					func = FN_VALIDATE;
					slot = h.slot;
					eg   = h.gen;
					idx  = -1;
				end else begin
					func = FN_INVAL;
				end
			end else if (pick >= 90) begin
				func = 2'($urandom_range(0, 3));
				held = 1'($urandom_range(0, 1));
			end
			issue_op(func, held, slot, eg, r);
			if (func == FN_ALLOC && !held && r.status == ST_OK) begin
				h.slot = r.slot;
				h.gen  = r.gen;
				live_handles = {live_handles, h};
			end else if (func == FN_INVAL && idx >= 0) begin
				retire_handle(live_handles[idx]);
				live_handles.delete(idx);
			end
		end
	endtask

	// response side: ready drops for random stretches when idling is on
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_if.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (snk_idle && $urandom_range(0, 3) == 0) begin
			rsp_if.ready <= 1'b0;
			stall_left = idle_len() - 1;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// in-order response check against the scoreboard queue
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected response slot %0d gen %0d valid %0b status %0d",
					$time, rsp_if.slot_out, rsp_if.generation, rsp_if.handle_valid,
					rsp_if.status);
			end else begin
				want_res = pending_results.pop_front();
				check_field("slot_out",     want_res.slot,         rsp_if.slot_out);
				check_field("generation",   want_res.gen,          rsp_if.generation);
				check_field("handle_valid", want_res.handle_valid, rsp_if.handle_valid);
				check_field("status",       want_res.status,       rsp_if.status);
				status_seen[want_res.status]++;
				results_seen++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n                     = 1'b0;
		req_if.valid               = 1'b0;
		req_if.func                = FN_ALLOC;
		req_if.holds_slot          = 1'b0;
		req_if.slot                = '0;
		req_if.expected_generation = '0;
		rsp_if.ready               = 1'b0;
		// pool after reset: generations zero, stack full with entry i = slot i
		for (int i = 0; i < SLOTS; i++) begin
			gen_tbl[i]  = '0;
			free_stk[i] = slot_t'(i);
		end
		free_cnt = SLOTS;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		src_idle = 1'b1;
		snk_idle = 1'b1;
		test_exhaust();
		test_traffic(90);
		src_idle = 1'b0;
		snk_idle = 1'b0;
		test_traffic(90);
		src_idle = 1'b1;
		test_traffic(90);
		src_idle = 1'b0;
		snk_idle = 1'b1;
		test_traffic(90);
		req_if.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("tb: %0d request items sent, %0d responses checked, %0d errors",
			items_sent, results_seen, errors);
		$display("tb: status counts ok %0d, no-free %0d, mismatch %0d, overflow %0d",
			status_seen[ST_OK], status_seen[ST_NOFREE], status_seen[ST_MISMATCH],
			status_seen[ST_OVERFLOW]);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
